>>> rtl/dle_stx_frame_encoder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the DLE/STX frame encoder
// Clocked concurrent checks with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef DLE_STX_FRAME_ENCODER_CORE_MACROS_SVH
`define DLE_STX_FRAME_ENCODER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSFE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsfe assertion failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define DSFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsfe assertion failed (next cycle)");

`endif

>>> rtl/dsfe_pkg.sv
// ----------------------------------------------------------------------------
// dsfe_pkg
// Shared types and line constants of the DLE/STX frame encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsfe_pkg;

  localparam logic [7:0] DLE_BYTE  = 8'h10;
  localparam logic [7:0] STX_BYTE  = 8'h02;
  localparam logic [7:0] ETX_BYTE  = 8'h03;
  localparam logic [7:0] DELIM_SUM = 8'h25;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_first;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_end;
  } out_item_t;

  // One classified byte, as handed from the front to the back.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first;
    logic       last;
    logic       is_dle;
    logic [7:0] checksum;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/dle_stx_frame_encoder_core.sv
// Each accepted input is queued, loaded into the current-byte register and then
// its line bytes enter the output register one per cycle while out_stall is low;
// an input yields 1 to 7 line bytes (escape, opening and closing delimiters,
// checksum), set by the back sequencer. Inputs are taken every cycle while the
// QUEUE_DEPTH-entry queue has room. Reset (rst, synchronous): empties the queue,
// drops any byte in flight and clears the running checksum.
// ----------------------------------------------------------------------------
// dle_stx_frame_encoder_core
// DLE/STX/ETX byte-stuffing framer with checksum, front/queue/back structure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dle_stx_frame_encoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dsfe_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dsfe_pkg::out_item_t out_item
);
  import dsfe_pkg::*;

  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  q_stat_t q_stat;

  dsfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dsfe_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  dsfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> rtl/dsfe_front.sv
// ----------------------------------------------------------------------------
// dsfe_front
// Accepts input bytes, flags escapes and keeps the running checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsfe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dsfe_pkg::in_item_t in_item,
  input  dsfe_pkg::q_stat_t q_stat,
  output logic              push,
  output dsfe_pkg::cmd_t    push_cmd
);
  import dsfe_pkg::*;

  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [7:0] sum_base;
  logic [7:0] sum_data;
  logic       is_dle;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;
  assign is_dle   = (in_item.payload_byte == DLE_BYTE);

  always_comb begin
    sum_base = in_item.frame_first ? 8'h00 : running_sum;
    sum_data = sum_base + in_item.payload_byte + (is_dle ? DLE_BYTE : 8'h00);
    running_sum_next = in_item.frame_last ? 8'h00 : sum_data;
    push_cmd.payload_byte = in_item.payload_byte;
    push_cmd.first        = in_item.frame_first;
    push_cmd.last         = in_item.frame_last;
    push_cmd.is_dle       = is_dle;
    push_cmd.checksum     = sum_data + DELIM_SUM;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 8'h00;
    end else if (push) begin
      running_sum <= running_sum_next;
    end
  end

endmodule

>>> rtl/dsfe_queue.sv
// ----------------------------------------------------------------------------
// dsfe_queue
// Small FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dle_stx_frame_encoder_core_macros.svh"

module dsfe_queue #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dsfe_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output dsfe_pkg::cmd_t    pop_cmd,
  output dsfe_pkg::q_stat_t q_stat
);
  import dsfe_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_stat.full  = (count == FULL_CNT);
  assign q_stat.empty = (count == '0);
  assign pop_cmd      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `DSFE_ASSERT_SAME(a_no_push_full, clk, rst, q_stat.full, !push)
  `DSFE_ASSERT_SAME(a_no_pop_empty, clk, rst, pop, !q_stat.empty)
  `DSFE_ASSERT_NEXT(a_count_bump, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

>>> rtl/dsfe_back.sv
// ----------------------------------------------------------------------------
// dsfe_back
// Sequences the line bytes of each classified byte into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dle_stx_frame_encoder_core_macros.svh"

module dsfe_back (
  input  logic               clk,
  input  logic               rst,
  input  dsfe_pkg::q_stat_t  q_stat,
  input  dsfe_pkg::cmd_t     pop_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output dsfe_pkg::out_item_t out_item
);
  import dsfe_pkg::*;

  typedef enum logic [2:0] {
    PH_OPEN_DLE,
    PH_OPEN_STX,
    PH_STUFF,
    PH_DATA,
    PH_CLOSE_DLE,
    PH_CLOSE_ETX,
    PH_CHECK
  } phase_t;

  cmd_t       cur;
  logic       cur_valid;
  phase_t     phase;
  phase_t     phase_next;
  phase_t     start_phase;
  logic       emit;
  logic       final_byte;
  logic [7:0] byte_sel;

  always_comb begin
    emit       = (!out_valid || !out_stall) && cur_valid;
    final_byte = (phase == PH_CHECK) || ((phase == PH_DATA) && !cur.last);
    pop        = !q_stat.empty && (!cur_valid || (emit && final_byte));

    if (pop_cmd.first) begin
      start_phase = PH_OPEN_DLE;
    end else if (pop_cmd.is_dle) begin
      start_phase = PH_STUFF;
    end else begin
      start_phase = PH_DATA;
    end

    case (phase)
      PH_OPEN_DLE: begin
        byte_sel   = DLE_BYTE;
        phase_next = PH_OPEN_STX;
      end
      PH_OPEN_STX: begin
        byte_sel   = STX_BYTE;
        phase_next = cur.is_dle ? PH_STUFF : PH_DATA;
      end
      PH_STUFF: begin
        byte_sel   = DLE_BYTE;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        byte_sel   = cur.payload_byte;
        phase_next = PH_CLOSE_DLE;
      end
      PH_CLOSE_DLE: begin
        byte_sel   = DLE_BYTE;
        phase_next = PH_CLOSE_ETX;
      end
      PH_CLOSE_ETX: begin
        byte_sel   = ETX_BYTE;
        phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        byte_sel   = cur.checksum;
        phase_next = PH_CHECK;
      end
      default: begin
        byte_sel   = cur.payload_byte;
        phase_next = PH_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      phase     <= PH_DATA;
    end else begin
      // Load the output register when a byte is current and the register is free or being drained.
      if (emit) begin
        out_valid         <= 1'b1;
        out_item.line_byte <= byte_sel;
        out_item.run_end   <= final_byte;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (pop) begin
        cur       <= pop_cmd;
        cur_valid <= 1'b1;
        phase     <= start_phase;
      end else if (emit) begin
        if (final_byte) begin
          cur_valid <= 1'b0;
        end else begin
          phase <= phase_next;
        end
      end
    end
  end

  `DSFE_ASSERT_NEXT(a_run_continues, clk, rst, out_valid && !out_stall && !out_item.run_end,
                    out_valid)
  `DSFE_ASSERT_SAME(a_check_needs_last, clk, rst, cur_valid && phase == PH_CHECK, cur.last)
  `DSFE_ASSERT_SAME(a_stuff_needs_dle, clk, rst, cur_valid && phase == PH_STUFF, cur.is_dle)

endmodule
